// ===== hw/rtl/ssc_pkg.sv =====
// Shared types, constants and helpers of the speed sign controller.
`default_nettype none

package ssc_pkg;

	localparam int TICKS_PER_SECOND = 100;
	localparam int TICK_W           = 7;
	localparam logic [TICK_W-1:0] TICK_LIMIT = TICK_W'(TICKS_PER_SECOND);

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 8;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_DAY_FIRST      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DAY_LAST       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DAY_LIMIT      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_NIGHT_LIMIT    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FAST_THRESHOLD = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_FAST_OFFSET    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_SLOW_OFFSET    = 3'd7;

	localparam logic [7:0] ASCII_CR    = 8'd13;
	localparam logic [7:0] ASCII_SPACE = 8'd32;
	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [6:0] THREE_DIGIT_SPEED = 7'd99;

	localparam logic [1:0] LAMP_OFF   = 2'd0;
	localparam logic [1:0] LAMP_DAY   = 2'd1;
	localparam logic [1:0] LAMP_NIGHT = 2'd2;

	localparam logic EVT_FRAME   = 1'b0;
	localparam logic EVT_TIMEOUT = 1'b1;

	typedef enum logic [1:0] {
		CMD_BYTE = 2'd0,
		CMD_TICK = 2'd1,
		CMD_HOUR = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		POS_FIRST,
		POS_SECOND,
		POS_THIRD,
		POS_FOURTH,
		POS_FIFTH
	} pos_t;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_TWO,
		KIND_THREE
	} kind_t;

	typedef struct packed {
		logic [4:0] day_first_hour;
		logic [4:0] day_last_hour;
		logic [7:0] day_limit;
		logic [7:0] night_limit;
		logic [7:0] timeout_seconds;
		logic [6:0] fast_threshold;
		logic [3:0] fast_offset;
		logic [3:0] slow_offset;
	} cfg_t;

	typedef struct packed {
		logic       event_kind;
		logic [6:0] speed;
		logic       frame_error;
		logic       digits_update;
		logic [7:0] tens_segments;
		logic [7:0] ones_segments;
		logic [1:0] limit_lamp;
		logic       red_on;
		logic       green_on;
	} res_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= ASCII_ZERO) && (b <= ASCII_ZERO + 8'd9);
	endfunction

	// a..g,dp in bits 7..0; anything above nine is blank
	function automatic logic [7:0] seg_of(input logic [3:0] v);
		logic [7:0] s;
		case (v)
			4'd0: s = 8'b1111_1100;
			4'd1: s = 8'b0110_0000;
			4'd2: s = 8'b1101_1010;
			4'd3: s = 8'b1111_0010;
			4'd4: s = 8'b0110_0110;
			4'd5: s = 8'b1011_0110;
			4'd6: s = 8'b1011_1110;
			4'd7: s = 8'b1110_0000;
			4'd8: s = 8'b1111_1110;
			4'd9: s = 8'b1111_0110;
			default: s = 8'b0000_0000;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/speed_sign_controller.sv =====
// Top level of the speed sign controller: input stage, engine and result register.
//
// Radar speed sign controller. Each request on the input channel is a radar
// ASCII byte (cmd 0), a 10 ms tick (cmd 1) or a BCD hour update (cmd 2);
// cmd 3 is dropped. A request is taken into an input register, handled in
// one pass by the engine when that register advances, and any result lands
// in a result register. The block accepts one request per cycle sustained;
// the input register only holds (and stall rises) while the result register
// is full and stalled downstream. A frame result is produced by the byte that
// completes a frame; a blanking result by the tick that reaches the timeout
// in seconds. Hour updates and mid-frame bytes produce no result.
// Configuration registers are written over the cfg channel, which is always
// ready; write them only while the block is idle.
`default_nettype none

module speed_sign_controller (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      cmd,
	input  wire logic [7:0]                      data,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 event_kind,
	output logic [6:0]                           speed,
	output logic                                 frame_error,
	output logic                                 digits_update,
	output logic [7:0]                           tens_segments,
	output logic [7:0]                           ones_segments,
	output logic [1:0]                           limit_lamp,
	output logic                                 red_on,
	output logic                                 green_on,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ssc_pkg::*;

	cfg_t       cfg;

	// input stage
	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] data_s1;

	// result register
	logic       out_valid_q;
	res_t       res_q;

	logic       advance;
	logic       res_valid;
	res_t       res;

	ssc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the stage moves whenever the result register is empty or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd;
			data_s1 <= data;
		end
	end

	ssc_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance),
		.cmd       (cmd_s1),
		.data      (data_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign event_kind    = res_q.event_kind;
	assign speed         = res_q.speed;
	assign frame_error   = res_q.frame_error;
	assign digits_update = res_q.digits_update;
	assign tens_segments = res_q.tens_segments;
	assign ones_segments = res_q.ones_segments;
	assign limit_lamp    = res_q.limit_lamp;
	assign red_on        = res_q.red_on;
	assign green_on      = res_q.green_on;

	// an accepted request is always held in the input stage next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted request missing from input stage");

	// stall only comes from a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without downstream back-pressure");

	// a new result always comes from a request that was in the input stage
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a request");

endmodule

`default_nettype wire

// ===== hw/rtl/ssc_cfg_regs.sv =====
// Configuration register file of the speed sign controller.
`default_nettype none

module ssc_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [ssc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [ssc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output ssc_pkg::cfg_t                       cfg
);
	import ssc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.day_first_hour  <= 5'd7;
			cfg_q.day_last_hour   <= 5'd18;
			cfg_q.day_limit       <= 8'd30;
			cfg_q.night_limit     <= 8'd50;
			cfg_q.timeout_seconds <= 8'd5;
			cfg_q.fast_threshold  <= 7'd45;
			cfg_q.fast_offset     <= 4'd5;
			cfg_q.slow_offset     <= 4'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DAY_FIRST:      cfg_q.day_first_hour  <= cfg_data[4:0];
				REG_DAY_LAST:       cfg_q.day_last_hour   <= cfg_data[4:0];
				REG_DAY_LIMIT:      cfg_q.day_limit       <= cfg_data;
				REG_NIGHT_LIMIT:    cfg_q.night_limit     <= cfg_data;
				REG_TIMEOUT:        cfg_q.timeout_seconds <= cfg_data;
				REG_FAST_THRESHOLD: cfg_q.fast_threshold  <= cfg_data[6:0];
				REG_FAST_OFFSET:    cfg_q.fast_offset     <= cfg_data[3:0];
				REG_SLOW_OFFSET:    cfg_q.slow_offset     <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ssc_engine.sv =====
// Frame parser, timeout counter and result builder of the speed sign controller.
`default_nettype none

module ssc_engine (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          go,
	input  wire logic [1:0]    cmd,
	input  wire logic [7:0]    data,
	input  wire ssc_pkg::cfg_t cfg,
	output logic               res_valid,
	output ssc_pkg::res_t      res
);
	import ssc_pkg::*;

	pos_t              pos_q, pos_n;
	kind_t             kind_q, kind_n;
	logic [7:0]        first_q, first_n;
	logic [7:0]        second_q, second_n;
	logic              fourth_cr_q, fourth_cr_n;
	logic [TICK_W-1:0] tick_q, tick_n;
	logic [7:0]        sec_q, sec_n;
	logic [7:0]        hour_q, hour_n;
	logic              latched_q, latched_n;
	logic [1:0]        lamp_q, lamp_n;

	logic              fin;
	logic [6:0]        fin_spd;
	logic              fin_err;
	logic              blank;
	logic [6:0]        two_val;
	logic [6:0]        two_spd;
	logic [14:0]       tens_prod;
	logic [3:0]        tens;
	logic [6:0]        tens_x10;
	logic [3:0]        ones;
	logic              day;
	logic [7:0]        limit;
	logic              red;
	logic [TICK_W-1:0] tick_inc;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_FIRST;
			kind_q      <= KIND_NONE;
			first_q     <= '0;
			second_q    <= '0;
			fourth_cr_q <= 1'b0;
			tick_q      <= '0;
			sec_q       <= '0;
			hour_q      <= '0;
			latched_q   <= 1'b0;
			lamp_q      <= LAMP_OFF;
		end else if (go) begin
			pos_q       <= pos_n;
			kind_q      <= kind_n;
			first_q     <= first_n;
			second_q    <= second_n;
			fourth_cr_q <= fourth_cr_n;
			tick_q      <= tick_n;
			sec_q       <= sec_n;
			hour_q      <= hour_n;
			latched_q   <= latched_n;
			lamp_q      <= lamp_n;
		end
	end

	// two-digit value: digits checked before use, low nibble is the digit
	assign two_val = 7'({first_q[3:0], 3'b000}) + 7'({first_q[3:0], 1'b0})
		+ 7'(second_q[3:0]);
	assign two_spd = two_val + ((two_val > cfg.fast_threshold)
		? 7'(cfg.fast_offset) : 7'(cfg.slow_offset));

	assign day = ({3'b000, cfg.day_first_hour} <= hour_q)
		&& (hour_q <= {3'b000, cfg.day_last_hour});
	assign limit = day ? cfg.day_limit : cfg.night_limit;

	// divide by ten: x*205 >> 11 is exact over the speed range
	assign tens_prod = 15'(fin_spd) * 15'd205;
	assign tens      = tens_prod[14:11];
	assign tens_x10  = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
	assign ones      = 4'(fin_spd - tens_x10);
	assign red       = {1'b0, fin_spd} > limit;

	assign tick_inc = tick_q + TICK_W'(1);

	always_comb begin
		pos_n       = pos_q;
		kind_n      = kind_q;
		first_n     = first_q;
		second_n    = second_q;
		fourth_cr_n = fourth_cr_q;
		tick_n      = tick_q;
		sec_n       = sec_q;
		hour_n      = hour_q;
		latched_n   = latched_q;
		lamp_n      = lamp_q;
		fin         = 1'b0;
		fin_spd     = '0;
		fin_err     = 1'b0;
		blank       = 1'b0;

		case (cmd)
			CMD_BYTE: begin
				case (pos_q)
					POS_FIRST: begin
						first_n = data;
						pos_n   = POS_SECOND;
					end
					POS_SECOND: begin
						second_n = data;
						pos_n    = POS_THIRD;
					end
					POS_THIRD: begin
						if (data == ASCII_CR) begin
							kind_n = KIND_TWO;
							pos_n  = POS_FOURTH;
						end else if (data == ASCII_SPACE) begin
							fin     = 1'b1;
							fin_spd = is_digit(first_q) ? 7'(first_q[3:0]) : 7'd0;
						end else if (is_digit(data)) begin
							kind_n = KIND_THREE;
							pos_n  = POS_FOURTH;
						end else begin
							fin     = 1'b1;
							fin_err = 1'b1;
						end
					end
					POS_FOURTH: begin
						if (kind_q == KIND_THREE) begin
							fourth_cr_n = (data == ASCII_CR);
							pos_n       = POS_FIFTH;
						end else begin
							fin = 1'b1;
							if (is_digit(first_q) && is_digit(second_q))
								fin_spd = two_spd;
						end
					end
					default: begin
						fin = 1'b1;
						if (fourth_cr_q && (data == ASCII_SPACE))
							fin_spd = THREE_DIGIT_SPEED;
					end
				endcase
			end
			CMD_TICK: begin
				if (tick_inc >= TICK_LIMIT) begin
					tick_n = '0;
					sec_n  = sec_q + 8'd1;
				end else begin
					tick_n = tick_inc;
				end
				if (sec_n >= cfg.timeout_seconds) begin
					blank     = 1'b1;
					sec_n     = '0;
					latched_n = 1'b0;
					lamp_n    = LAMP_OFF;
				end
			end
			CMD_HOUR: begin
				hour_n = 8'({data[7:4], 3'b000}) + 8'({data[7:4], 1'b0})
					+ 8'(data[3:0]);
			end
			default: ;
		endcase

		if (fin) begin
			pos_n       = POS_FIRST;
			kind_n      = KIND_NONE;
			fourth_cr_n = 1'b0;
			tick_n      = '0;
			sec_n       = '0;
			if (!latched_q) begin
				lamp_n    = day ? LAMP_DAY : LAMP_NIGHT;
				latched_n = 1'b1;
			end
		end
	end

	always_comb begin
		res       = '0;
		res_valid = fin || blank;
		if (blank) begin
			res.event_kind    = EVT_TIMEOUT;
			res.digits_update = 1'b1;
		end else begin
			res.event_kind  = EVT_FRAME;
			res.speed       = fin_spd;
			res.frame_error = fin_err;
			res.limit_lamp  = lamp_n;
			res.red_on      = red;
			res.green_on    = !red;
			if (fin_spd != 7'd0) begin
				res.digits_update = 1'b1;
				res.tens_segments = (tens != 4'd0) ? seg_of(tens) : 8'd0;
				res.ones_segments = seg_of(ones);
			end
		end
	end

endmodule

`default_nettype wire

// ===== tb/speed_sign_controller_tb.sv =====
// Self-checking testbench of the speed sign controller: random and directed requests, checked results.
module speed_sign_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssc_pkg::*;

	// cmd value outside the enum; the block drops it without a result
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// idle cycles allowed after the last expected result before a register write
	localparam int SETTLE_CYCLES = 4;
	// cycles with no request, result or write moving before the run is declared hung
	localparam int WATCHDOG_LIMIT = 1000;
	// keep a broken block from flooding the log; every mismatch is still counted
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] val;
	} sign_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] cmd = CMD_BYTE;
	logic [7:0] data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       event_kind;
	logic [6:0] speed;
	logic       frame_error;
	logic       digits_update;
	logic [7:0] tens_segments;
	logic [7:0] ones_segments;
	logic [1:0] limit_lamp;
	logic       red_on;
	logic       green_on;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	speed_sign_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.data(data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.speed(speed),
		.frame_error(frame_error),
		.digits_update(digits_update),
		.tens_segments(tens_segments),
		.ones_segments(ones_segments),
		.limit_lamp(limit_lamp),
		.red_on(red_on),
		.green_on(green_on),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------
	sign_req_t req_backlog [$];        // requests not yet offered to the block
	res_t      sign_updates_due [$];   // predicted results, oldest first
	int        req_count = 0;          // requests queued, dropped cmd excluded
	int        mismatch_count = 0;
	logic      calm = 1'b0;            // no idling on either side once set
	int        gap_left = 0;
	int        hold_left = 0;
	int        quiet_cycles = 0;
	sign_req_t next_req;
	res_t      want;

	// Predictor's copy of the registers, at their reset values
	cfg_t sign_regs = {5'd7, 5'd18, 8'd30, 8'd50, 8'd5, 7'd45, 4'd5, 4'd3};

	// Predictor's copy of the parser, the timeout counters and the lamp
	pos_t       parse_pos = POS_FIRST;
	kind_t      frame_form = KIND_NONE;
	logic [7:0] first_b = '0;
	logic [7:0] second_b = '0;
	logic       cr_fourth = 1'b0;
	logic [6:0] tick_cnt = '0;
	logic [7:0] sec_cnt = '0;
	logic [7:0] hour_now = '0;
	logic       lamp_held = 1'b0;
	logic [1:0] lamp_now = LAMP_OFF;

	task automatic log_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("%0t ns mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] exp_v);
		if (got !== exp_v)
			log_mismatch($sformatf("%s got %0h, expected %0h", name, got, exp_v));
	endtask

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic logic is_ascii_digit(input logic [7:0] b);
		return b >= ASCII_ZERO && b <= ASCII_ZERO + 8'd9;
	endfunction

	// a..g,dp in bits 7..0; tens values above nine stay dark
	function automatic logic [7:0] segs_for(input int v);
		case (v)
			0: return 8'hFC;
			1: return 8'h60;
			2: return 8'hDA;
			3: return 8'hF2;
			4: return 8'h66;
			5: return 8'hB6;
			6: return 8'hBE;
			7: return 8'hE0;
			8: return 8'hFE;
			9: return 8'hF6;
			default: return 8'h00;
		endcase
	endfunction

	// A frame ends: parser and timeout counters restart, lamp latches on the first frame
	task automatic close_frame(input int spd, input logic err);
		res_t r;
		logic is_day;
		int   lim;
		parse_pos = POS_FIRST;
		frame_form = KIND_NONE;
		cr_fourth = 1'b0;
		tick_cnt = '0;
		sec_cnt = '0;
		is_day = hour_now >= sign_regs.day_first_hour && hour_now <= sign_regs.day_last_hour;
		if (!lamp_held) begin
			lamp_now = is_day ? LAMP_DAY : LAMP_NIGHT;
			lamp_held = 1'b1;
		end
		lim = is_day ? int'(sign_regs.day_limit) : int'(sign_regs.night_limit);
		r = '0;
		r.event_kind = EVT_FRAME;
		r.speed = 7'(spd);
		r.frame_error = err;
		r.digits_update = spd != 0;
		r.tens_segments = (spd != 0 && spd / 10 != 0) ? segs_for(spd / 10) : 8'h00;
		r.ones_segments = (spd != 0) ? segs_for(spd % 10) : 8'h00;
		r.limit_lamp = lamp_now;
		r.red_on = spd > lim;
		r.green_on = !(spd > lim);
		sign_updates_due.push_back(r);
	endtask

	// Advance the predictor by one accepted request
	task automatic predict_sign(input logic [1:0] op, input logic [7:0] val);
		res_t r;
		int   two;
		case (op)
			CMD_BYTE: begin
				case (parse_pos)
					POS_FIRST: begin
						first_b = val;
						parse_pos = POS_SECOND;
					end
					POS_SECOND: begin
						second_b = val;
						parse_pos = POS_THIRD;
					end
					POS_THIRD: begin
						// third byte picks the format
						if (val == ASCII_CR) begin
							frame_form = KIND_TWO;
							parse_pos = POS_FOURTH;
						end else if (val == ASCII_SPACE) begin
							close_frame(is_ascii_digit(first_b) ? int'(first_b - ASCII_ZERO) : 0,
								1'b0);
						end else if (is_ascii_digit(val)) begin
							frame_form = KIND_THREE;
							parse_pos = POS_FOURTH;
						end else begin
							close_frame(0, 1'b1);
						end
					end
					POS_FOURTH: begin
						if (frame_form == KIND_THREE) begin
							cr_fourth = val == ASCII_CR;
							parse_pos = POS_FIFTH;
						end else if (is_ascii_digit(first_b) && is_ascii_digit(second_b)) begin
							two = int'(first_b - ASCII_ZERO) * 10 + int'(second_b - ASCII_ZERO);
							two += (two > int'(sign_regs.fast_threshold)) ?
								int'(sign_regs.fast_offset) : int'(sign_regs.slow_offset);
							close_frame(two, 1'b0);
						end else begin
							close_frame(0, 1'b0);
						end
					end
					default: begin
						close_frame((cr_fourth && val == ASCII_SPACE) ? int'(THREE_DIGIT_SPEED) : 0,
							1'b0);
					end
				endcase
			end
			CMD_TICK: begin
				tick_cnt = tick_cnt + 7'd1;
				if (tick_cnt >= TICK_LIMIT) begin
					sec_cnt = sec_cnt + 8'd1;
					tick_cnt = '0;
				end
				// blanking leaves the parser alone
				if (sec_cnt >= sign_regs.timeout_seconds) begin
					sec_cnt = '0;
					lamp_held = 1'b0;
					lamp_now = LAMP_OFF;
					r = '0;
					r.event_kind = EVT_TIMEOUT;
					r.digits_update = 1'b1;
					sign_updates_due.push_back(r);
				end
			end
			CMD_HOUR: begin
				// BCD with no range check, up to 165
				hour_now = 8'(int'(val[7:4]) * 10 + int'(val[3:0]));
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Request driver: offers the backlog, predicts on every accepted request
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			cmd <= CMD_BYTE;
			data <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_sign(cmd, data);
			// a stalled request holds as it is
			if (!in_valid || !in_stall) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (!calm && req_backlog.size() != 0 && $urandom_range(0, 11) == 0) begin
					// idle burst: valid stays low until gap_left runs out
					gap_left <= $urandom_range(0, 9);
					in_valid <= 1'b0;
				end else if (req_backlog.size() != 0) begin
					next_req = req_backlog.pop_front();
					in_valid <= 1'b1;
					cmd <= next_req.op;
					data <= next_req.val;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result monitor: random stall bursts, every accepted result checked
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (sign_updates_due.size() == 0) begin
					log_mismatch("result arrived with nothing expected");
				end else begin
					want = sign_updates_due.pop_front();
					compare_field("event_kind", event_kind, want.event_kind);
					compare_field("speed", speed, want.speed);
					compare_field("frame_error", frame_error, want.frame_error);
					compare_field("digits_update", digits_update, want.digits_update);
					compare_field("tens_segments", tens_segments, want.tens_segments);
					compare_field("ones_segments", ones_segments, want.ones_segments);
					compare_field("limit_lamp", limit_lamp, want.limit_lamp);
					compare_field("red_on", red_on, want.red_on);
					compare_field("green_on", green_on, want.green_on);
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				hold_left <= $urandom_range(0, 9);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with nothing moving on any channel ends the run
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("speed_sign_controller_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus builders
	// ------------------------------------------------------------------
	task automatic queue_req(input logic [1:0] op, input logic [7:0] val);
		req_backlog.push_back('{op: op, val: val});
		if (op != CMD_UNUSED)
			req_count++;
	endtask

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			queue_req(CMD_BYTE, s[i]);
	endtask

	function automatic logic [7:0] any_digit();
		return ASCII_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] digit_or_junk(input int junk_pct);
		if ($urandom_range(0, 99) < junk_pct)
			return 8'($urandom);
		return any_digit();
	endfunction

	// half plausible clock hours, half any byte
	function automatic logic [7:0] bcd_hour();
		int h;
		if ($urandom_range(0, 1) == 0)
			return 8'($urandom);
		h = $urandom_range(0, 23);
		return {4'(h / 10), 4'(h % 10)};
	endfunction

	// a radar byte, now and then with a tick or an hour update slipped in ahead
	task automatic queue_byte(input logic [7:0] b);
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			queue_req(CMD_TICK, 8'($urandom));
		else if (roll == 1)
			queue_req(CMD_HOUR, bcd_hour());
		queue_req(CMD_BYTE, b);
	endtask

	// one frame in a random format, content mostly well formed
	task automatic queue_frame();
		case ($urandom_range(0, 3))
			0: begin
				queue_byte(digit_or_junk(10));
				queue_byte(8'($urandom));
				queue_byte(ASCII_SPACE);
			end
			1: begin
				queue_byte(digit_or_junk(8));
				queue_byte(digit_or_junk(8));
				queue_byte(ASCII_CR);
				queue_byte(8'($urandom));
			end
			2: begin
				queue_byte(digit_or_junk(50));
				queue_byte(digit_or_junk(50));
				queue_byte(any_digit());
				queue_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : ASCII_CR);
				queue_byte(($urandom_range(0, 7) == 0) ? 8'($urandom) : ASCII_SPACE);
			end
			default: begin
				// third byte almost never fits a format
				queue_byte(8'($urandom));
				queue_byte(8'($urandom));
				queue_byte(8'($urandom));
			end
		endcase
	endtask

	// quiet_pct: share of tick runs that are long (60 to 230 ticks) rather than short (1 to 4)
	task automatic queue_random(input int n, input int quiet_pct);
		int start;
		int pick;
		int run;
		start = req_count;
		while (req_count - start < n) begin
			pick = $urandom_range(0, 99);
			if (pick < 68) begin
				queue_frame();
			end else if (pick < 78) begin
				queue_byte(8'($urandom));
			end else if (pick < 86) begin
				queue_req(CMD_HOUR, bcd_hour());
			end else if (pick < 88) begin
				queue_req(CMD_UNUSED, 8'($urandom));
			end else begin
				run = ($urandom_range(0, 99) < quiet_pct) ? $urandom_range(60, 230) :
					$urandom_range(1, 4);
				repeat (run) queue_req(CMD_TICK, 8'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Register writes, only with the block idle
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DAY_FIRST:      sign_regs.day_first_hour = val[4:0];
			REG_DAY_LAST:       sign_regs.day_last_hour = val[4:0];
			REG_DAY_LIMIT:      sign_regs.day_limit = val;
			REG_NIGHT_LIMIT:    sign_regs.night_limit = val;
			REG_TIMEOUT:        sign_regs.timeout_seconds = val;
			REG_FAST_THRESHOLD: sign_regs.fast_threshold = val[6:0];
			REG_FAST_OFFSET:    sign_regs.fast_offset = val[3:0];
			REG_SLOW_OFFSET:    sign_regs.slow_offset = val[3:0];
			default: ;
		endcase
	endtask

	task automatic load_regs(input cfg_t v);
		write_reg(REG_DAY_FIRST, 8'(v.day_first_hour));
		write_reg(REG_DAY_LAST, 8'(v.day_last_hour));
		write_reg(REG_DAY_LIMIT, v.day_limit);
		write_reg(REG_NIGHT_LIMIT, v.night_limit);
		write_reg(REG_TIMEOUT, v.timeout_seconds);
		write_reg(REG_FAST_THRESHOLD, 8'(v.fast_threshold));
		write_reg(REG_FAST_OFFSET, 8'(v.fast_offset));
		write_reg(REG_SLOW_OFFSET, 8'(v.slow_offset));
	endtask

	task automatic load_random_regs(input logic [7:0] secs);
		cfg_t v;
		v.day_first_hour = 5'($urandom_range(0, 23));
		v.day_last_hour = 5'($urandom_range(0, 23));
		v.day_limit = 8'($urandom);
		v.night_limit = 8'($urandom);
		v.timeout_seconds = secs;
		v.fast_threshold = 7'($urandom_range(0, 99));
		v.fast_offset = 4'($urandom);
		v.slow_offset = 4'($urandom);
		load_regs(v);
	endtask

	// Sampled on the falling edge so the driver's and monitor's updates have settled.
	// Bytes that end no frame give no result, hence the extra settle cycles.
	task automatic wait_idle();
		@(negedge clk);
		while (req_backlog.size() != 0 || in_valid || sign_updates_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : sequence_main
		cfg_t plan;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values; directed frames first
		queue_req(CMD_HOUR, 8'h12);          // noon, daytime: lamp latches to day
		queue_text("5\377 ");                // one digit, junk middle byte
		queue_text("99\015");                // 99 is fast: 104, tens dark
		queue_req(CMD_BYTE, 8'h00);
		queue_text("45\015x");               // right at the threshold: slow offset
		queue_text("123\015 ");              // three digits show 99
		queue_req(CMD_BYTE, 8'h00);          // third byte fits no format
		queue_text("7Z");
		queue_req(CMD_HOUR, 8'h99);          // hour 99: night limit from here
		queue_text("A1\015 ");               // not a digit: speed 0, digits held
		queue_req(CMD_UNUSED, 8'hAA);        // dropped
		queue_req(CMD_TICK, 8'h55);
		queue_random(300, 0);
		wait_idle();

		// Timeout of zero blanks on every tick; day window covers every valid hour
		plan.day_first_hour = 5'd0;
		plan.day_last_hour = 5'd23;
		plan.day_limit = 8'd0;
		plan.night_limit = 8'd255;
		plan.timeout_seconds = 8'd0;
		plan.fast_threshold = 7'd0;
		plan.fast_offset = 4'd15;
		plan.slow_offset = 4'd0;
		load_regs(plan);
		repeat (3) queue_req(CMD_TICK, 8'hFF);
		queue_text("00\015 ");               // zero plus no offset: speed 0
		queue_text("8");                     // ticks in mid frame leave the parser alone
		queue_req(CMD_TICK, 8'h00);
		queue_text("3 ");
		queue_random(150, 0);
		wait_idle();

		// First hour after last: always night. One-second timeout with long quiet stretches
		plan.day_first_hour = 5'd23;
		plan.day_last_hour = 5'd0;
		plan.day_limit = 8'd255;
		plan.night_limit = 8'd0;
		plan.timeout_seconds = 8'd1;
		plan.fast_threshold = 7'd99;
		plan.fast_offset = 4'd0;
		plan.slow_offset = 4'd15;
		load_regs(plan);
		queue_random(450, 40);
		wait_idle();

		load_random_regs(8'd2);
		queue_random(300, 20);
		wait_idle();

		// Closing stretch runs with no idling on either side
		calm <= 1'b1;
		load_random_regs(8'd255);
		queue_random(250, 20);
		wait_idle();

		if (mismatch_count == 0 && sign_updates_due.size() == 0)
			$display("speed_sign_controller_tb: done, clean");
		else
			$display("speed_sign_controller_tb: done, errors");
		$finish;
	end

endmodule
